FILE: rtl/csba_pkg.sv
// ----------------------------------------------------------------------------
// csba_pkg
// Shared constants, codes and types of the compacting slot block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csba_pkg;

  // Store geometry
  localparam int TOTAL_BLOCKS = 56;
  localparam int BLOCK_BYTES  = 256;
  localparam int SLOT_COUNT   = 10;

  // Widths
  localparam int BLK_W   = $clog2(TOTAL_BLOCKS + 1);
  localparam int BYTES_W = 15;
  localparam int SIZE_W  = 16;
  localparam int ALU_W   = 16;
  localparam int LEN_W   = 14;
  localparam int ID_W    = 4;
  localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [1:0] {
    CMD_RESET  = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_NOSLOT  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ALU_CEIL   = 2'd0,  // bytes -> whole blocks
    ALU_REM    = 2'd1,  // block index -> bytes above it
    ALU_SUBSAT = 2'd2   // saturating subtract
  } alu_op_e;

  typedef struct packed {
    alu_op_e            op;
    logic [ALU_W-1:0]   a;
    logic [BLK_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [BLK_W-1:0]   start;
    logic [BYTES_W-1:0] bytes;
  } slot_ent_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    slot_ent_t          ent;
  } tbl_wr_t;

endpackage

`default_nettype wire

FILE: rtl/csba_alu.sv
// ----------------------------------------------------------------------------
// csba_alu
// Shared block arithmetic: round up to blocks, bytes above a block,
// saturating subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csba_alu (
  input  csba_pkg::alu_req_t         req_i,
  output logic [csba_pkg::ALU_W-1:0] y_o
);

  logic [csba_pkg::ALU_W:0]   sum;
  logic [csba_pkg::ALU_W-1:0] b_ext;

  assign sum   = {1'b0, req_i.a} + (csba_pkg::ALU_W + 1)'(csba_pkg::BLOCK_BYTES - 1);
  assign b_ext = csba_pkg::ALU_W'(req_i.b);

  always_comb begin
    case (req_i.op)
      csba_pkg::ALU_CEIL: begin
        y_o = csba_pkg::ALU_W'(sum / csba_pkg::BLOCK_BYTES);
      end
      csba_pkg::ALU_REM: begin
        if (req_i.a < csba_pkg::ALU_W'(csba_pkg::TOTAL_BLOCKS)) begin
          y_o = csba_pkg::ALU_W'((csba_pkg::ALU_W'(csba_pkg::TOTAL_BLOCKS) - req_i.a)
                * csba_pkg::ALU_W'(csba_pkg::BLOCK_BYTES));
        end else begin
          y_o = '0;
        end
      end
      csba_pkg::ALU_SUBSAT: begin
        y_o = (req_i.a > b_ext) ? (req_i.a - b_ext) : '0;
      end
      default: begin
        y_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/csba_table.sv
// ----------------------------------------------------------------------------
// csba_table
// Slot table: first block and byte length per slot, one walk port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csba_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [csba_pkg::IDX_W-1:0]  rd_idx_i,
  output csba_pkg::slot_ent_t         rd_o,
  input  csba_pkg::tbl_wr_t           wr_i
);

  csba_pkg::slot_ent_t ent_q [csba_pkg::SLOT_COUNT];

  assign rd_o = ent_q[rd_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < csba_pkg::SLOT_COUNT; i++) begin
        ent_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      ent_q[wr_i.idx] <= wr_i.ent;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/csba_ctrl.sv
// ----------------------------------------------------------------------------
// csba_ctrl
// Command sequencer: gather walk, block arithmetic steps, update walk,
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csba_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic [csba_pkg::ID_W-1:0]     slot_id_i,
  input  logic [csba_pkg::SIZE_W-1:0]   byte_size_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [3:0]                    slot_out_o,
  output logic [5:0]                    start_block_o,
  output logic [13:0]                   byte_length_o,
  output logic [5:0]                    move_from_block_o,
  output logic [13:0]                   move_bytes_o,
  output logic [13:0]                   remaining_bytes_o,
  output logic                          free_slot_valid_o,
  output logic [3:0]                    free_slot_o,
  output logic [csba_pkg::IDX_W-1:0]    tbl_rd_idx_o,
  input  csba_pkg::slot_ent_t           tbl_rd_i,
  output csba_pkg::tbl_wr_t             tbl_wr_o,
  output csba_pkg::alu_req_t            alu_req_o,
  input  logic [csba_pkg::ALU_W-1:0]    alu_y_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GATHER,
    S_CEIL,
    S_CHECK,
    S_MOVE,
    S_APPLY,
    S_NEXT,
    S_REMOUT,
    S_FINISH
  } state_e;

  localparam logic [csba_pkg::IDX_W-1:0] LAST_IDX = csba_pkg::IDX_W'(csba_pkg::SLOT_COUNT - 1);

  state_e                          state_q;
  csba_pkg::cmd_e                  cmd_q;
  logic [csba_pkg::ID_W-1:0]       id_q;
  logic [csba_pkg::SIZE_W-1:0]     size_q;
  logic [csba_pkg::IDX_W-1:0]      idx_q;
  logic                            found_q;
  logic [csba_pkg::IDX_W-1:0]      fidx_q;
  logic                            hit_q;
  logic [csba_pkg::BLK_W-1:0]      first_q;
  logic [csba_pkg::BYTES_W-1:0]    nbytes_q;
  logic [csba_pkg::BLK_W-1:0]      nb_q;
  logic [csba_pkg::BLK_W-1:0]      next_q;
  logic                            commit_q;
  logic                            free_v_q;
  logic [csba_pkg::IDX_W-1:0]      free_idx_q;

  // result being built
  csba_pkg::status_e               r_status_q;
  logic [3:0]                      r_slot_q;
  logic [5:0]                      r_start_q;
  logic [13:0]                     r_len_q;
  logic [5:0]                      r_mfrom_q;
  logic [13:0]                     r_mbytes_q;
  logic [13:0]                     r_rem_q;

  // check step outcome
  csba_pkg::status_e               r_status_d;
  logic                            commit_d;
  logic [3:0]                      r_slot_d;
  logic [5:0]                      r_start_d;
  logic [13:0]                     r_len_d;
  logic [5:0]                      r_mfrom_d;

  // output register
  logic                            out_valid_q;
  logic [1:0]                      o_status_q;
  logic [3:0]                      o_slot_q;
  logic [5:0]                      o_start_q;
  logic [13:0]                     o_len_q;
  logic [5:0]                      o_mfrom_q;
  logic [13:0]                     o_mbytes_q;
  logic [13:0]                     o_rem_q;
  logic                            o_fv_q;
  logic [3:0]                      o_fs_q;

  logic [csba_pkg::BLK_W:0]        mfrom;
  logic                            idx_is_id;
  logic [csba_pkg::BYTES_W-1:0]    post_bytes;
  logic [csba_pkg::ALU_W:0]        rem_ext;

  assign mfrom      = {1'b0, first_q} + {1'b0, nb_q};
  assign idx_is_id  = (csba_pkg::ID_W'(idx_q) == id_q);
  assign post_bytes = tbl_wr_o.en ? tbl_wr_o.ent.bytes : tbl_rd_i.bytes;
  assign rem_ext    = {1'b0, alu_y_i};

  assign in_ready_o   = (state_q == S_IDLE);
  assign tbl_rd_idx_o = idx_q;

  // shared unit operand select
  always_comb begin
    alu_req_o.op = csba_pkg::ALU_SUBSAT;
    alu_req_o.a  = '0;
    alu_req_o.b  = nb_q;
    case (state_q)
      S_CEIL: begin
        alu_req_o.op = csba_pkg::ALU_CEIL;
        alu_req_o.a  = (cmd_q == csba_pkg::CMD_ALLOC) ? size_q
                                                       : csba_pkg::ALU_W'(nbytes_q);
      end
      S_CHECK, S_REMOUT: begin
        alu_req_o.op = csba_pkg::ALU_REM;
        alu_req_o.a  = csba_pkg::ALU_W'(next_q);
      end
      S_MOVE: begin
        alu_req_o.op = csba_pkg::ALU_REM;
        alu_req_o.a  = csba_pkg::ALU_W'(mfrom);
      end
      S_APPLY: begin
        alu_req_o.a  = csba_pkg::ALU_W'(tbl_rd_i.start);
      end
      S_NEXT: begin
        alu_req_o.a  = csba_pkg::ALU_W'(next_q);
      end
      default: begin
        alu_req_o.a  = '0;
      end
    endcase
  end

  // status and result fields decided in the check step
  always_comb begin
    r_status_d = csba_pkg::ST_OK;
    commit_d   = 1'b0;
    r_slot_d   = '0;
    r_start_d  = '0;
    r_len_d    = '0;
    r_mfrom_d  = '0;
    case (cmd_q)
      csba_pkg::CMD_RESET: begin
        commit_d = 1'b1;
      end
      csba_pkg::CMD_ALLOC: begin
        // space check comes before the slot check
        if (rem_ext < {1'b0, size_q}) begin
          r_status_d = csba_pkg::ST_NOSPACE;
        end else if (!found_q) begin
          r_status_d = csba_pkg::ST_NOSLOT;
        end else begin
          commit_d  = 1'b1;
          r_slot_d  = 4'(fidx_q);
          r_start_d = 6'(next_q);
          r_len_d   = size_q[13:0];
        end
      end
      csba_pkg::CMD_DELETE: begin
        r_slot_d = id_q;
        if (!hit_q) begin
          r_status_d = csba_pkg::ST_EMPTY;
        end else begin
          commit_d  = 1'b1;
          r_start_d = 6'(first_q);
          r_mfrom_d = 6'(mfrom);
        end
      end
      default: begin
        r_slot_d = id_q;
        if (!hit_q) begin
          r_status_d = csba_pkg::ST_EMPTY;
        end else begin
          r_start_d = 6'(first_q);
          r_len_d   = nbytes_q[13:0];
        end
      end
    endcase
  end

  // table update during the second walk
  always_comb begin
    tbl_wr_o.en  = 1'b0;
    tbl_wr_o.idx = idx_q;
    tbl_wr_o.ent = tbl_rd_i;
    if (state_q == S_APPLY) begin
      case (cmd_q)
        csba_pkg::CMD_RESET: begin
          tbl_wr_o.en  = 1'b1;
          tbl_wr_o.ent = '0;
        end
        csba_pkg::CMD_ALLOC: begin
          if (commit_q && idx_q == fidx_q) begin
            tbl_wr_o.en        = 1'b1;
            tbl_wr_o.ent.start = next_q;
            tbl_wr_o.ent.bytes = csba_pkg::BYTES_W'(size_q);
          end
        end
        csba_pkg::CMD_DELETE: begin
          if (commit_q) begin
            if (idx_is_id) begin
              tbl_wr_o.en  = 1'b1;
              tbl_wr_o.ent = '0;
            end else if (tbl_rd_i.start > first_q) begin
              tbl_wr_o.en        = 1'b1;
              tbl_wr_o.ent.start = csba_pkg::BLK_W'(alu_y_i);
            end
          end
        end
        default: begin
          tbl_wr_o.en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_q      <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      hit_q       <= 1'b0;
      commit_q    <= 1'b0;
      free_v_q    <= 1'b0;
    end else begin
      // the finish step reloads the output register itself
      if (out_valid_q && out_ready_i && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q    <= csba_pkg::cmd_e'(command_i);
            id_q     <= slot_id_i;
            size_q   <= byte_size_i;
            idx_q    <= '0;
            found_q  <= 1'b0;
            fidx_q   <= '0;
            hit_q    <= 1'b0;
            first_q  <= '0;
            nbytes_q <= '0;
            state_q  <= S_GATHER;
          end
        end
        S_GATHER: begin
          if (tbl_rd_i.bytes == '0 && !found_q) begin
            found_q <= 1'b1;
            fidx_q  <= idx_q;
          end
          if (idx_is_id) begin
            first_q  <= tbl_rd_i.start;
            nbytes_q <= tbl_rd_i.bytes;
            hit_q    <= (tbl_rd_i.bytes != '0);
          end
          if (idx_q == LAST_IDX) begin
            idx_q   <= '0;
            state_q <= S_CEIL;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_CEIL: begin
          nb_q    <= csba_pkg::BLK_W'(alu_y_i);
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          r_status_q <= r_status_d;
          r_slot_q   <= r_slot_d;
          r_start_q  <= r_start_d;
          r_len_q    <= r_len_d;
          r_mfrom_q  <= r_mfrom_d;
          r_mbytes_q <= '0;
          commit_q   <= commit_d;
          state_q    <= S_MOVE;
        end
        S_MOVE: begin
          if (cmd_q == csba_pkg::CMD_DELETE && commit_q) begin
            r_mbytes_q <= alu_y_i[13:0];
          end
          free_v_q   <= 1'b0;
          free_idx_q <= '0;
          idx_q      <= '0;
          state_q    <= S_APPLY;
        end
        S_APPLY: begin
          // lowest empty slot, as the table reads after this write
          if (post_bytes == '0 && !free_v_q) begin
            free_v_q   <= 1'b1;
            free_idx_q <= idx_q;
          end
          if (idx_q == LAST_IDX) begin
            idx_q   <= '0;
            state_q <= S_NEXT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_NEXT: begin
          if (commit_q) begin
            case (cmd_q)
              csba_pkg::CMD_RESET:  next_q <= '0;
              csba_pkg::CMD_ALLOC:  next_q <= next_q + nb_q;
              csba_pkg::CMD_DELETE: next_q <= csba_pkg::BLK_W'(alu_y_i);
              default:              next_q <= next_q;
            endcase
          end
          state_q <= S_REMOUT;
        end
        S_REMOUT: begin
          r_rem_q <= alu_y_i[13:0];
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            o_status_q  <= r_status_q;
            o_slot_q    <= r_slot_q;
            o_start_q   <= r_start_q;
            o_len_q     <= r_len_q;
            o_mfrom_q   <= r_mfrom_q;
            o_mbytes_q  <= r_mbytes_q;
            o_rem_q     <= r_rem_q;
            o_fv_q      <= free_v_q;
            o_fs_q      <= free_v_q ? 4'(free_idx_q) : 4'd0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = o_status_q;
  assign slot_out_o        = o_slot_q;
  assign start_block_o     = o_start_q;
  assign byte_length_o     = o_len_q;
  assign move_from_block_o = o_mfrom_q;
  assign move_bytes_o      = o_mbytes_q;
  assign remaining_bytes_o = o_rem_q;
  assign free_slot_valid_o = o_fv_q;
  assign free_slot_o       = o_fs_q;

endmodule

`default_nettype wire

FILE: rtl/compacting_slot_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// compacting_slot_block_allocator_unit
// Slot table allocator over a block store with compaction on delete.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | beat
//  --------+-----------+-------------------------+--------------------------------
//  in      | input     | in_valid_i / in_ready_o | command, slot id, byte size
//  out     | output    | out_valid_o/out_ready_i | status, location, move, free info
//
//  One command runs from its beat to its result as two walks over the slot table
//  through one port and one shared block-arithmetic unit; the next beat can be
//  taken as soon as the result is loaded into the output register.
//  in_ready_o is high only while the sequencer is idle.
//  A finished result waits in the output register; a stalled result delays
//  the next result but not acceptance of the next command.
//  rst_ni clears the slot table and the next-free-block pointer at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module compacting_slot_block_allocator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   command_i,
  input  logic [3:0]   slot_id_i,
  input  logic [15:0]  byte_size_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [1:0]   status_o,
  output logic [3:0]   slot_out_o,
  output logic [5:0]   start_block_o,
  output logic [13:0]  byte_length_o,
  output logic [5:0]   move_from_block_o,
  output logic [13:0]  move_bytes_o,
  output logic [13:0]  remaining_bytes_o,
  output logic         free_slot_valid_o,
  output logic [3:0]   free_slot_o
);

  logic [csba_pkg::IDX_W-1:0] tbl_rd_idx;
  csba_pkg::slot_ent_t        tbl_rd;
  csba_pkg::tbl_wr_t          tbl_wr;
  csba_pkg::alu_req_t         alu_req;
  logic [csba_pkg::ALU_W-1:0] alu_y;

  csba_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (tbl_rd_idx),
    .rd_o     (tbl_rd),
    .wr_i     (tbl_wr)
  );

  csba_alu u_alu (
    .req_i (alu_req),
    .y_o   (alu_y)
  );

  csba_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .slot_id_i         (slot_id_i),
    .byte_size_i       (byte_size_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .slot_out_o        (slot_out_o),
    .start_block_o     (start_block_o),
    .byte_length_o     (byte_length_o),
    .move_from_block_o (move_from_block_o),
    .move_bytes_o      (move_bytes_o),
    .remaining_bytes_o (remaining_bytes_o),
    .free_slot_valid_o (free_slot_valid_o),
    .free_slot_o       (free_slot_o),
    .tbl_rd_idx_o      (tbl_rd_idx),
    .tbl_rd_i          (tbl_rd),
    .tbl_wr_o          (tbl_wr),
    .alu_req_o         (alu_req),
    .alu_y_i           (alu_y)
  );

endmodule

`default_nettype wire

FILE: rtl/csba_checker.sv
// ----------------------------------------------------------------------------
// csba_port_checks
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csba_port_checks (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_ready_o,
  input  logic         out_valid_o,
  input  logic         out_ready_i,
  input  logic [1:0]   status_o,
  input  logic [3:0]   slot_out_o,
  input  logic [5:0]   start_block_o,
  input  logic [13:0]  byte_length_o,
  input  logic [5:0]   move_from_block_o,
  input  logic [13:0]  move_bytes_o,
  input  logic [13:0]  remaining_bytes_o,
  input  logic         free_slot_valid_o,
  input  logic [3:0]   free_slot_o
);

  // a command keeps the block busy after its beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("in_ready_o still high after an accepted beat");

  // a result stays up until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(slot_out_o) && $stable(start_block_o) && $stable(byte_length_o) &&
    $stable(move_from_block_o) && $stable(move_bytes_o) &&
    $stable(remaining_bytes_o) && $stable(free_slot_valid_o) && $stable(free_slot_o))
    else $error("stalled result dropped or changed");

  // no free slot reports slot zero
  a_free_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !free_slot_valid_o |-> free_slot_o == 4'd0)
    else $error("free_slot_o nonzero without a free slot");

  // a failed command carries no copy length
  a_fail_no_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != csba_pkg::ST_OK |->
    byte_length_o == 14'd0 && move_bytes_o == 14'd0)
    else $error("failed command reports copy bytes");

  // remaining space is a whole number of blocks
  a_rem_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> remaining_bytes_o[7:0] == 8'd0)
    else $error("remaining_bytes_o not block aligned");

endmodule

bind compacting_slot_block_allocator_unit csba_port_checks u_port_checks (.*);

`default_nettype wire

FILE: tb/csba_checker.sv
// ----------------------------------------------------------------------------
// csba_checker
// Watches both channels of the slot block allocator. Every accepted command
// updates a private copy of the slot table and queues the result it should
// give; every accepted result beat is compared field by field with the
// oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csba_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  logic [1:0]   command_i,
  input  logic [3:0]   slot_id_i,
  input  logic [15:0]  byte_size_i,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic [1:0]   status_i,
  input  logic [3:0]   slot_out_i,
  input  logic [5:0]   start_block_i,
  input  logic [13:0]  byte_length_i,
  input  logic [5:0]   move_from_block_i,
  input  logic [13:0]  move_bytes_i,
  input  logic [13:0]  remaining_bytes_i,
  input  logic         free_slot_valid_i,
  input  logic [3:0]   free_slot_i,
  output int unsigned  mismatch_cnt_o,
  output int unsigned  owed_cnt_o
);

  typedef struct packed {
    csba_pkg::status_e status;
    logic [3:0]        slot;
    logic [5:0]        start;
    logic [13:0]       blen;
    logic [5:0]        mfrom;
    logic [13:0]       mbytes;
    logic [13:0]       remain;
    logic              fvalid;
    logic [3:0]        fslot;
  } alloc_result_t;

  logic [csba_pkg::BLK_W-1:0]   tbl_start [csba_pkg::SLOT_COUNT];
  logic [csba_pkg::BYTES_W-1:0] tbl_bytes [csba_pkg::SLOT_COUNT];
  logic [csba_pkg::BLK_W-1:0]   tbl_next;
  alloc_result_t                awaited_results [$];

  task automatic report_mismatch(string msg);
    if (mismatch_cnt_o < 100) $display("[%0t] csba: %s", $time, msg);
    mismatch_cnt_o++;
  endtask

  function automatic void clear_table();
    for (int i = 0; i < csba_pkg::SLOT_COUNT; i++) begin
      tbl_start[i] = '0;
      tbl_bytes[i] = '0;
    end
    tbl_next = '0;
  endfunction

  function automatic int free_bytes();
    if (int'(tbl_next) >= csba_pkg::TOTAL_BLOCKS) return 0;
    return (csba_pkg::TOTAL_BLOCKS - int'(tbl_next)) * csba_pkg::BLOCK_BYTES;
  endfunction

  function automatic int blocks_for(int bytes);
    return (bytes + csba_pkg::BLOCK_BYTES - 1) / csba_pkg::BLOCK_BYTES;
  endfunction

  // a slot with zero length counts as empty, even right after a zero-size alloc
  function automatic int lowest_empty();
    for (int i = 0; i < csba_pkg::SLOT_COUNT; i++)
      if (tbl_bytes[i] == '0) return i;
    return -1;
  endfunction

  function automatic alloc_result_t apply_command(csba_pkg::cmd_e cmd, logic [3:0] id,
                                                  logic [15:0] size);
    alloc_result_t r;
    int idx, first, nblk, top_blk;
    bit occupied;
    r = '0;
    case (cmd)
      csba_pkg::CMD_RESET: begin
        clear_table();
      end
      csba_pkg::CMD_ALLOC: begin
        // space is checked before slot availability
        if (int'(size) > free_bytes()) begin
          r.status = csba_pkg::ST_NOSPACE;
        end else begin
          idx = lowest_empty();
          if (idx < 0) begin
            r.status = csba_pkg::ST_NOSLOT;
          end else begin
            r.slot = 4'(idx);
            r.start = tbl_next;
            r.blen = 14'(size);
            tbl_start[idx] = tbl_next;
            tbl_bytes[idx] = csba_pkg::BYTES_W'(size);
            tbl_next = csba_pkg::BLK_W'(int'(tbl_next) + blocks_for(int'(size)));
          end
        end
      end
      default: begin
        r.slot = id;
        occupied = 1'b0;
        if (int'(id) < csba_pkg::SLOT_COUNT) occupied = (tbl_bytes[id] != '0);
        if (!occupied) begin
          r.status = csba_pkg::ST_EMPTY;
        end else if (cmd == csba_pkg::CMD_READ) begin
          r.start = tbl_start[id];
          r.blen = 14'(tbl_bytes[id]);
        end else begin
          first = int'(tbl_start[id]);
          nblk = blocks_for(int'(tbl_bytes[id]));
          top_blk = first + nblk;
          r.start = 6'(first);
          r.mfrom = 6'(top_blk);
          r.mbytes = (top_blk < csba_pkg::TOTAL_BLOCKS) ?
                     14'((csba_pkg::TOTAL_BLOCKS - top_blk) * csba_pkg::BLOCK_BYTES) : '0;
          // compaction: everything above the gap slides down
          for (int i = 0; i < csba_pkg::SLOT_COUNT; i++) begin
            if (i != int'(id) && int'(tbl_start[i]) > first)
              tbl_start[i] = (int'(tbl_start[i]) > nblk) ?
                             csba_pkg::BLK_W'(int'(tbl_start[i]) - nblk) : '0;
          end
          tbl_start[id] = '0;
          tbl_bytes[id] = '0;
          tbl_next = (int'(tbl_next) > nblk) ? csba_pkg::BLK_W'(int'(tbl_next) - nblk) : '0;
        end
      end
    endcase
    idx = lowest_empty();
    r.remain = 14'(free_bytes());
    r.fvalid = (idx >= 0);
    r.fslot = (idx >= 0) ? 4'(idx) : '0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t got, want;
    if (!rst_ni) begin
      clear_table();
      awaited_results.delete();
      mismatch_cnt_o = 0;
      owed_cnt_o = 0;
    end else begin
      // result first: it always belongs to an earlier command
      if (out_valid_i && out_ready_i) begin
        got = '{status: csba_pkg::status_e'(status_i), slot: slot_out_i,
                start: start_block_i, blen: byte_length_i, mfrom: move_from_block_i,
                mbytes: move_bytes_i, remain: remaining_bytes_i,
                fvalid: free_slot_valid_i, fslot: free_slot_i};
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result beat with none awaited (status %0d slot %0d)",
                                    got.status, got.slot));
        end else begin
          want = awaited_results.pop_front();
          if (got.status != want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.slot != want.slot)
            report_mismatch($sformatf("slot_out %0d, want %0d", got.slot, want.slot));
          if (got.start != want.start)
            report_mismatch($sformatf("start_block %0d, want %0d", got.start, want.start));
          if (got.blen != want.blen)
            report_mismatch($sformatf("byte_length %0d, want %0d", got.blen, want.blen));
          if (got.mfrom != want.mfrom)
            report_mismatch($sformatf("move_from_block %0d, want %0d",
                                      got.mfrom, want.mfrom));
          if (got.mbytes != want.mbytes)
            report_mismatch($sformatf("move_bytes %0d, want %0d", got.mbytes, want.mbytes));
          if (got.remain != want.remain)
            report_mismatch($sformatf("remaining_bytes %0d, want %0d",
                                      got.remain, want.remain));
          if (got.fvalid != want.fvalid)
            report_mismatch($sformatf("free_slot_valid %0d, want %0d",
                                      got.fvalid, want.fvalid));
          if (got.fslot != want.fslot)
            report_mismatch($sformatf("free_slot %0d, want %0d", got.fslot, want.fslot));
        end
      end
      if (in_valid_i && in_ready_i)
        awaited_results.push_back(apply_command(csba_pkg::cmd_e'(command_i), slot_id_i,
                                                byte_size_i));
      owed_cnt_o = awaited_results.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives commands into the slot block allocator: a directed opening over
// the corner cases, then random traffic in three idle regimes, with a long
// output hold-off and drain pauses. The checker does the comparing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 340;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_ready_o;
  logic [1:0]   command_i = csba_pkg::CMD_RESET;
  logic [3:0]   slot_id_i = '0;
  logic [15:0]  byte_size_i = '0;
  logic         out_valid_o;
  logic         out_ready_i = 1'b0;
  logic [1:0]   status_o;
  logic [3:0]   slot_out_o;
  logic [5:0]   start_block_o;
  logic [13:0]  byte_length_o;
  logic [5:0]   move_from_block_o;
  logic [13:0]  move_bytes_o;
  logic [13:0]  remaining_bytes_o;
  logic         free_slot_valid_o;
  logic [3:0]   free_slot_o;

  int unsigned  mismatch_total;
  int unsigned  results_owed;
  int unsigned  cycle_cnt = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           hold_req = 0;
  int           hold_ack = 0;
  int           hold_left = 0;

  compacting_slot_block_allocator_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .slot_id_i         (slot_id_i),
    .byte_size_i       (byte_size_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .slot_out_o        (slot_out_o),
    .start_block_o     (start_block_o),
    .byte_length_o     (byte_length_o),
    .move_from_block_o (move_from_block_o),
    .move_bytes_o      (move_bytes_o),
    .remaining_bytes_o (remaining_bytes_o),
    .free_slot_valid_o (free_slot_valid_o),
    .free_slot_o       (free_slot_o)
  );

  csba_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .command_i         (command_i),
    .slot_id_i         (slot_id_i),
    .byte_size_i       (byte_size_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_i          (status_o),
    .slot_out_i        (slot_out_o),
    .start_block_i     (start_block_o),
    .byte_length_i     (byte_length_o),
    .move_from_block_i (move_from_block_o),
    .move_bytes_i      (move_bytes_o),
    .remaining_bytes_i (remaining_bytes_o),
    .free_slot_valid_i (free_slot_valid_o),
    .free_slot_i       (free_slot_o),
    .mismatch_cnt_o    (mismatch_total),
    .owed_cnt_o        (results_owed)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("compacting_slot_block_allocator_unit: mismatch");
      $finish;
    end
  end

  // Result side: random back-pressure, or a long hold when one is requested
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_cmd(csba_pkg::cmd_e cmd, logic [3:0] id, logic [15:0] size);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    slot_id_i <= id;
    byte_size_i <= size;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (results_owed != 0) @(negedge clk_i);
  endtask

  task automatic send_random();
    int pick;
    csba_pkg::cmd_e cmd;
    logic [3:0] id;
    logic [15:0] size;
    pick = $urandom_range(99);
    if (pick < 2) cmd = csba_pkg::CMD_RESET;
    else if (pick < 47) cmd = csba_pkg::CMD_ALLOC;
    else if (pick < 72) cmd = csba_pkg::CMD_DELETE;
    else cmd = csba_pkg::CMD_READ;
    // mostly real slots, sometimes beyond the table
    id = ($urandom_range(99) < 85) ? 4'($urandom_range(csba_pkg::SLOT_COUNT - 1))
                                   : 4'($urandom_range(15, csba_pkg::SLOT_COUNT));
    pick = $urandom_range(99);
    if (pick < 55) size = 16'($urandom_range(2048, 1));
    else if (pick < 65) size = 16'(csba_pkg::BLOCK_BYTES * $urandom_range(8));
    else if (pick < 72) size = 16'(csba_pkg::BLOCK_BYTES * $urandom_range(8, 1) + 1);
    else if (pick < 85)
      size = 16'($urandom_range(csba_pkg::TOTAL_BLOCKS * csba_pkg::BLOCK_BYTES));
    else size = 16'($urandom);
    send_cmd(cmd, id, size);
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed opening
    send_cmd(csba_pkg::CMD_RESET, 4'd0, 16'd0);
    send_cmd(csba_pkg::CMD_READ, 4'd0, 16'd0);
    send_cmd(csba_pkg::CMD_READ, 4'd15, 16'hffff);
    send_cmd(csba_pkg::CMD_DELETE, 4'd12, 16'd0);
    send_cmd(csba_pkg::CMD_DELETE, 4'd3, 16'd0);
    // fills the store
    send_cmd(csba_pkg::CMD_ALLOC, 4'd0,
             16'(csba_pkg::TOTAL_BLOCKS * csba_pkg::BLOCK_BYTES));
    send_cmd(csba_pkg::CMD_ALLOC, 4'd0, 16'd0);   // zero size, no space left
    send_cmd(csba_pkg::CMD_ALLOC, 4'd0, 16'd1);
    send_cmd(csba_pkg::CMD_READ, 4'd0, 16'd0);
    send_cmd(csba_pkg::CMD_DELETE, 4'd0, 16'd0);
    send_cmd(csba_pkg::CMD_RESET, 4'd9, 16'hffff);
    for (int i = 0; i < csba_pkg::SLOT_COUNT; i++)
      send_cmd(csba_pkg::CMD_ALLOC, 4'(i), 16'(100 + 200 * i));
    send_cmd(csba_pkg::CMD_ALLOC, 4'd0, 16'd1);       // table full
    send_cmd(csba_pkg::CMD_ALLOC, 4'd0, 16'hffff);    // space check wins over full table
    send_cmd(csba_pkg::CMD_DELETE, 4'd4, 16'd0);
    send_cmd(csba_pkg::CMD_READ, 4'd9, 16'd0);
    send_cmd(csba_pkg::CMD_DELETE, 4'd9, 16'd0);
    send_cmd(csba_pkg::CMD_RESET, 4'd0, 16'd0);
    drain();

    tx_idle_pct = 37;
    rx_idle_pct = 86;
    repeat (PHASE_ITEMS) send_random();
    drain();

    tx_idle_pct = 86;
    rx_idle_pct = 37;
    repeat (PHASE_ITEMS) send_random();
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // long output stall with commands still offered: the block backs up
    hold_req = hold_req + 1;
    repeat (30) send_random();
    drain();
    repeat (PHASE_ITEMS) send_random();

    drain();
    repeat (60) @(negedge clk_i);
    if (mismatch_total == 0) begin
      $display("compacting_slot_block_allocator_unit: match");
    end else begin
      $display("compacting_slot_block_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule
